// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/iopb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopb_pkg
// Shared constants, codes and control/status types of the I/O permission
// bitmap block.
// ----------------------------------------------------------------------------
package iopb_pkg;

  localparam int MAP_BYTES = 8192;
  localparam int PORT_BITS = 16;

  localparam int PORT_W = 16;
  localparam int CNT_W  = 14;
  localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  localparam logic [PORT_W-1:0] PORT_MASK = PORT_W'((32'd1 << PORT_BITS) - 32'd1);
  localparam logic [CNT_W-1:0]  MAP_LIMIT = CNT_W'(MAP_BYTES);
  localparam logic [CNT_W-1:0]  MAP_LAST  = CNT_W'(MAP_BYTES - 1);
  localparam logic [7:0]        BYTE_FULL = 8'hff;

  typedef enum logic [1:0] {
    OP_GRANT    = 2'd0,
    OP_REVOKE   = 2'd1,
    OP_CHECK    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RD_WALK  = 2'd0,
    RD_CHECK = 2'd1,
    RD_TRIM  = 2'd2,
    RD_NONE  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    clr_write;
    logic    walk_start;
    logic    rd;
    rd_sel_t rd_sel;
    logic    wr_walk;
    logic    grant_count;
    logic    trim_dec;
    logic    result_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_bad;
    logic revoke_ok;
    logic walk_in_map;
    logic walk_at_last;
    logic clr_done;
    logic used_zero;
    logic byte_full;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/iopb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopb_datapath
// Bitmap memory, request registers, byte walker, used-byte count and the
// result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iopb_datapath import iopb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [1:0]        in_op,
  input  logic [PORT_W-1:0] in_first,
  input  logic [PORT_W-1:0] in_last,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_status,
  output logic [CNT_W-1:0]  out_used,
  output logic              out_allowed
);

  logic [7:0]        mem [MAP_BYTES];
  op_t               op;
  logic [PORT_W-1:0] first;
  logic [PORT_W-1:0] last;
  logic [CNT_W-1:0]  walk;
  logic [CNT_W-1:0]  used;
  logic [7:0]        rd_data;

  logic [CNT_W-1:0]  first_byte;
  logic [CNT_W-1:0]  last_byte;
  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  used_m1;
  logic [2:0]        lo_bit;
  logic [2:0]        hi_bit;
  logic [7:0]        mask;
  logic [7:0]        wr_data;
  logic [CNT_W-1:0]  rd_idx;
  logic              wr_en;
  logic              res_status;
  logic              res_allowed;

  assign first_byte = CNT_W'(first >> 3);
  assign last_byte  = CNT_W'(last >> 3);
  assign need       = (last_byte >= MAP_LAST) ? MAP_LIMIT : last_byte + CNT_W'(1);
  assign used_m1    = used - CNT_W'(1);
  assign lo_bit     = (walk == first_byte) ? first[2:0] : 3'd0;
  assign hi_bit     = (walk == last_byte) ? last[2:0] : 3'd7;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask[i] = (3'(i) >= lo_bit) && (3'(i) <= hi_bit);
    end
  end

  assign wr_data = cmd.clr_write ? BYTE_FULL :
                   (op == OP_GRANT) ? (rd_data & ~mask) : (rd_data | mask);
  assign wr_en   = cmd.clr_write || cmd.wr_walk;

  always_comb begin
    case (cmd.rd_sel)
      RD_CHECK: rd_idx = first_byte;
      RD_TRIM:  rd_idx = used_m1;
      default:  rd_idx = walk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[walk[ADDR_W-1:0]] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= op_t'(in_op);
      first <= in_first & PORT_MASK;
      last  <= in_last & PORT_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
      used <= '0;
    end else begin
      if (cmd.walk_start) begin
        walk <= first_byte;
      end else if (wr_en) begin
        walk <= walk + CNT_W'(1);
      end
      if (cmd.grant_count && (need > used)) begin
        used <= need;
      end else if (cmd.trim_dec) begin
        used <= used_m1;
      end
    end
  end

  assign res_status  = ((op == OP_GRANT) || (op == OP_REVOKE)) && (first > last);
  assign res_allowed = (op == OP_CHECK) && (first_byte < MAP_LIMIT) &&
                       !rd_data[first[2:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      out_status  <= res_status;
      out_used    <= used;
      out_allowed <= res_allowed;
    end
  end

  assign sts.op           = op;
  assign sts.range_bad    = first > last;
  assign sts.revoke_ok    = first_byte < used;
  assign sts.walk_in_map  = walk < MAP_LIMIT;
  assign sts.walk_at_last = walk == last_byte;
  assign sts.clr_done     = walk == MAP_LAST;
  assign sts.used_zero    = used == '0;
  assign sts.byte_full    = rd_data == BYTE_FULL;
  assign sts.out_free     = !out_valid || out_ready;

  `ASSERT_CLK(a_used_bound, used <= MAP_LIMIT, "used byte count beyond map")
  `ASSERT_CLK(a_wr_in_map, wr_en |-> walk < MAP_LIMIT, "bitmap write outside map")
  `ASSERT_CLK(a_trim_nonzero, cmd.trim_dec |-> !sts.used_zero && sts.byte_full,
              "trim of a byte that is not all ones")

endmodule

// ===== rtl/iopb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iopb_ctrl
// Sequencer: clearing pass, request decode, byte walk, count trim and
// result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iopb_ctrl import iopb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_DECODE   = 9'b000000100,
    S_RD       = 9'b000001000,
    S_WR       = 9'b000010000,
    S_TRIM_RD  = 9'b000100000,
    S_TRIM_CHK = 9'b001000000,
    S_CHECK    = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_NONE;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          OP_CHECK: begin
            cmd.rd     = 1'b1;
            cmd.rd_sel = RD_CHECK;
            state_next = S_CHECK;
          end
          OP_GRANT: begin
            if (sts.range_bad) begin
              state_next = S_DONE;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_RD;
            end
          end
          OP_REVOKE: begin
            if (sts.range_bad || !sts.revoke_ok) begin
              state_next = S_DONE;
            end else begin
              cmd.walk_start = 1'b1;
              state_next     = S_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RD: begin
        if (sts.walk_in_map) begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = RD_WALK;
          state_next = S_WR;
        end else if (sts.op == OP_GRANT) begin
          cmd.grant_count = 1'b1;
          state_next      = S_DONE;
        end else begin
          state_next = S_TRIM_RD;
        end
      end
      S_WR: begin
        cmd.wr_walk = 1'b1;
        if (!sts.walk_at_last) begin
          state_next = S_RD;
        end else if (sts.op == OP_GRANT) begin
          cmd.grant_count = 1'b1;
          state_next      = S_DONE;
        end else begin
          state_next = S_TRIM_RD;
        end
      end
      S_TRIM_RD: begin
        if (sts.used_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.rd     = 1'b1;
          cmd.rd_sel = RD_TRIM;
          state_next = S_TRIM_CHK;
        end
      end
      S_TRIM_CHK: begin
        if (sts.byte_full) begin
          cmd.trim_dec = 1'b1;
          state_next   = S_TRIM_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHECK: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  `ASSERT_CLK(a_load_decode, cmd.load |=> state == S_DECODE, "request load without decode")
  `ASSERT_CLK(a_result_free, cmd.result_load |-> sts.out_free,
              "result loaded over a pending result")
  `ASSERT_CLK(a_wr_after_rd, state == S_WR |-> $past(cmd.rd) && $past(cmd.rd_sel == RD_WALK),
              "byte write without its read")

endmodule

// ===== rtl/io_permission_bitmap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_permission_bitmap_core
// I/O port permission bitmap: grant, revoke and check of port permissions.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: s_tuser carries the operation (grant,
// revoke, check), s_tdata the first and last port. Every request yields one
// result on the m_ stream: status, used byte count and the allowed flag.
// Requests are handled one at a time. A check reads the addressed bitmap
// byte after decode and hands off its result. A grant or revoke does a
// read-modify-write of each bitmap byte in the range (over the single memory
// port), after decode and before handoff. A revoke then probes the trailing
// bytes: each all-ones byte is trimmed off the count, and the trim stops at
// a byte that is not all ones or when the count reaches zero. An inverted
// range, a revoke beyond the count and the unused code skip to handoff.
// After reset a clearing pass sets all 8192 bitmap bytes to all ones, one
// byte a cycle; s_tready stays low until the pass is done. The count resets
// to zero.
// A finished result waits in the output register while m_tready is low; the
// next request is accepted and worked on meanwhile, and it stalls only when
// its own result is ready and the register is still full.
// ----------------------------------------------------------------------------
module io_permission_bitmap_core import iopb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] first_port, [31:16] last_port
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] status, [14:1] used_bytes, [15] allowed
);

  cmd_t             cmd;
  sts_t             sts;
  logic             out_status;
  logic [CNT_W-1:0] out_used;
  logic             out_allowed;

  iopb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iopb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_first    (s_tdata[15:0]),
    .in_last     (s_tdata[31:16]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_status  (out_status),
    .out_used    (out_used),
    .out_allowed (out_allowed)
  );

  assign m_tdata = {out_allowed, out_used, out_status};

endmodule

// ===== bench/tb_io_permission_bitmap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_io_permission_bitmap_core
// Self-checking bench for the I/O permission bitmap core.
// ----------------------------------------------------------------------------
// A short table of directed requests covers empty-map behavior, inverted
// ranges, the unused operation code, full-range grant and revoke, byte
// boundaries and count trimming. Random requests follow, mostly clustered
// in a low port window so that grants, revokes and checks interact, with
// some scattered high ports and inverted ranges. Typed rows give their own
// expected result, a bench bitmap model the rest; all are compared field
// by field in order. Source and sink idle at random save in the last phase.
// ----------------------------------------------------------------------------
module tb_io_permission_bitmap_core;
  import iopb_pkg::*;

  typedef struct {
    logic        status;
    logic [13:0] used;
    logic        allowed;
  } result_t;

  typedef struct {
    op_t         op;
    logic [15:0] first;
    logic [15:0] last;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic [7:0]  permission_map [MAP_BYTES];
  int          used_count;
  result_t     pending_results [$];
  row_t        directed_rows [$];
  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          error_count = 0;
  int          results_seen = 0;
  int          op_counts [4] = '{0, 0, 0, 0};
  int          inverted_count = 0;
  int          peak_used = 0;

  io_permission_bitmap_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void fill_ports(input int lo, input int hi, input bit deny);
    for (int p = lo; p <= hi; p++) begin
      if ((p >> 3) < MAP_BYTES) permission_map[p >> 3][p & 7] = deny;
    end
  endfunction

  function automatic result_t apply_request(input op_t op, input logic [15:0] first_in,
                                            input logic [15:0] last_in);
    result_t     r;
    logic [15:0] first;
    logic [15:0] last;
    int          need;
    first = first_in & PORT_MASK;
    last = last_in & PORT_MASK;
    r.status = 1'b0;
    r.allowed = 1'b0;
    case (op)
      OP_GRANT, OP_REVOKE: begin
        if (first > last) begin
          r.status = 1'b1;
        end else if (op == OP_GRANT) begin
          fill_ports(first, last, 1'b0);
          need = int'(last >> 3) + 1;
          if (need > MAP_BYTES) need = MAP_BYTES;
          if (need > used_count) used_count = need;
        end else if (int'(first >> 3) + 1 <= used_count) begin
          fill_ports(first, last, 1'b1);
          while (used_count > 0 && used_count <= MAP_BYTES &&
                 permission_map[used_count - 1] == BYTE_FULL)
            used_count--;
        end
      end
      OP_CHECK: begin
        if ((first >> 3) < MAP_BYTES && permission_map[first >> 3][first[2:0]] == 1'b0)
          r.allowed = 1'b1;
      end
      default: ;
    endcase
    r.used = used_count[13:0];
    return r;
  endfunction

  task automatic send_request(input op_t op, input logic [15:0] first,
                              input logic [15:0] last, input bit typed,
                              input result_t want);
    result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {last, first};
    do @(posedge clk); while (!s_tready);
    predicted = apply_request(op, first, last);
    pending_results.push_back(typed ? want : predicted);
    op_counts[op]++;
    if ((op == OP_GRANT || op == OP_REVOKE) && first > last) inverted_count++;
    if (used_count > peak_used) peak_used = used_count;
  endtask

  task automatic add_row(input op_t op, input int first, input int last, input bit typed,
                         input bit status, input int used, input bit allowed);
    row_t row;
    row.op = op;
    row.first = first[15:0];
    row.last = last[15:0];
    row.typed = typed;
    row.want.status = status;
    row.want.used = used[13:0];
    row.want.allowed = allowed;
    directed_rows.push_back(row);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: tdata %h", m_tdata);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[0] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_tdata[0]);
          error_count++;
        end
        if (m_tdata[14:1] !== exp_r.used) begin
          $error("used_bytes: expected %0d, actual %0d", exp_r.used, m_tdata[14:1]);
          error_count++;
        end
        if (m_tdata[15] !== exp_r.allowed) begin
          $error("allowed: expected %0d, actual %0d", exp_r.allowed, m_tdata[15]);
          error_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    op_t     op;
    int      first;
    int      last;
    int      shape;
    int      pick;
    result_t none;
    none.status = 1'b0;
    none.used = '0;
    none.allowed = 1'b0;
    for (int i = 0; i < MAP_BYTES; i++) permission_map[i] = BYTE_FULL;
    used_count = 0;

    //      op           first  last   typed st used  allowed
    add_row(OP_CHECK,    0,     0,     1,    0, 0,    0);
    add_row(OP_CHECK,    65535, 0,     1,    0, 0,    0);
    add_row(OP_REVOKE,   0,     10,    1,    0, 0,    0);
    add_row(OP_GRANT,    5,     3,     1,    1, 0,    0);
    add_row(OP_REVOKE,   65535, 0,     1,    1, 0,    0);
    add_row(OP_RESERVED, 0,     65535, 1,    0, 0,    0);
    add_row(OP_GRANT,    0,     0,     1,    0, 1,    0);
    add_row(OP_CHECK,    0,     65535, 1,    0, 1,    1);
    add_row(OP_CHECK,    1,     0,     1,    0, 1,    0);
    add_row(OP_GRANT,    65535, 65535, 1,    0, 8192, 0);
    add_row(OP_CHECK,    65535, 65535, 1,    0, 8192, 1);
    add_row(OP_REVOKE,   65535, 65535, 1,    0, 1,    0);
    add_row(OP_GRANT,    100,   163,   0,    0, 0,    0);
    add_row(OP_REVOKE,   120,   130,   0,    0, 0,    0);
    add_row(OP_CHECK,    120,   0,     0,    0, 0,    0);
    add_row(OP_GRANT,    0,     65535, 1,    0, 8192, 0);
    add_row(OP_CHECK,    40000, 0,     1,    0, 8192, 1);
    add_row(OP_REVOKE,   0,     65535, 1,    0, 0,    0);
    add_row(OP_CHECK,    0,     0,     1,    0, 0,    0);
    add_row(OP_GRANT,    7,     8,     0,    0, 0,    0);
    add_row(OP_REVOKE,   8,     8,     0,    0, 0,    0);
    add_row(OP_CHECK,    7,     12345, 0,    0, 0,    0);
    add_row(OP_REVOKE,   800,   900,   0,    0, 0,    0);
    add_row(OP_GRANT,    65535, 0,     0,    0, 0,    0);
    add_row(OP_RESERVED, 65535, 65535, 0,    0, 0,    0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    sender_idle_pct = 36;
    sink_stall_pct = 49;
    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].first, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        drain_results();
        sender_idle_pct = 49;
        sink_stall_pct = 36;
      end else if (phase == 2) begin
        drain_results();
        sender_idle_pct = 0;
        sink_stall_pct = 0;
      end
      for (int n = 0; n < 125; n++) begin
        pick = $urandom_range(99);
        op = (pick < 35) ? OP_GRANT : (pick < 70) ? OP_REVOKE :
             (pick < 95) ? OP_CHECK : OP_RESERVED;
        shape = $urandom_range(99);
        if (shape < 90) begin
          first = $urandom_range(511);
          last = first + $urandom_range(23);
        end else if (shape < 97) begin
          first = $urandom_range(65535);
          last = first + $urandom_range(15);
          if (last > 65535) last = 65535;
        end else begin
          first = $urandom_range(65535, 1);
          last = $urandom_range(first - 1);
        end
        if (op == OP_CHECK) last = $urandom_range(65535);
        send_request(op, first[15:0], last[15:0], 1'b0, none);
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    $display("covered %0d requests: %0d grants, %0d revokes, %0d checks, %0d unused code",
             op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
             op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
    $display("%0d inverted ranges, %0d results checked, peak used bytes %0d",
             inverted_count, results_seen, peak_used);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/iopb_pkg.sv
rtl/iopb_datapath.sv
rtl/iopb_ctrl.sv
rtl/io_permission_bitmap_core.sv
bench/tb_io_permission_bitmap_core.sv
